[design/npbc_pkg.sv]
package npbc_pkg;

	// Default sizes of the point table.
	localparam int ENTRIES_DEF       = 16;
	localparam int COORD_BITS_DEF    = 16;
	localparam int CATEGORY_BITS_DEF = 8;

	// Fixed field widths on the ports.
	localparam int SLOT_W = 4;
	localparam int POS_W  = 16;
	localparam int CAT_W  = 8;
	localparam int D2_W   = 33;
	localparam int Q8_W   = 25;

	// Fraction bit pairs of the Q8 root and latency of the distance pipeline.
	localparam int FRAC_PAIRS   = 8;
	localparam int DRAIN_CYCLES = 3;

	// Operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// One request: a table load or a nearest query.
	typedef struct packed {
		logic                     operation;
		logic [SLOT_W-1:0]        slot;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic [CAT_W-1:0]         category;
	} req_t;

	// One query result.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] nearest_slot;
		logic [D2_W-1:0]   distance_squared;
		logic [Q8_W-1:0]   distance_q8;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic issue;
		logic root_init;
		logic root_step;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

[design/nearest_point_by_category.sv]
// Nearest-point search over a small table of points, each with a signed x, a
// signed y and a category. A load request (operation 0) writes one slot and
// marks it valid; busy stays low. A query request
// (operation 1) scans the table one slot per cycle through a single read port,
// keeps the valid entry of the wanted category with the least squared
// distance (the lower slot wins a tie), and then takes the square root in Q8
// one bit per cycle. The result is presented on result with done high for
// exactly one cycle, and busy drops the cycle after. The receiver cannot
// stall the result: it must take it in the cycle that done is high. found
// is clear and the other result fields are zero when no valid entry has the
// category. Valid marks are cleared by reset; no other clearing takes place.
module nearest_point_by_category #(
	parameter int ENTRIES       = npbc_pkg::ENTRIES_DEF,
	parameter int COORD_BITS    = npbc_pkg::COORD_BITS_DEF,
	parameter int CATEGORY_BITS = npbc_pkg::CATEGORY_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  npbc_pkg::req_t request,
	output logic           done,
	output npbc_pkg::rsp_t result
);
	import npbc_pkg::*;

	localparam int AW         = $clog2(ENTRIES);
	localparam int ROOT_STEPS = COORD_BITS + 1 + FRAC_PAIRS;

	cmd_t          cmd;
	logic [AW-1:0] rd_addr;

	// Sequencer for load, scan, drain and root phases.
	npbc_ctrl #(
		.ENTRIES    (ENTRIES),
		.ROOT_STEPS (ROOT_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// Table, distance pipeline, minimum tracking and square root.
	npbc_dp #(
		.ENTRIES       (ENTRIES),
		.COORD_BITS    (COORD_BITS),
		.CATEGORY_BITS (CATEGORY_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.result  (result)
	);

endmodule

[design/npbc_ctrl.sv]
module npbc_ctrl #(
	parameter int ENTRIES    = npbc_pkg::ENTRIES_DEF,
	parameter int ROOT_STEPS = npbc_pkg::COORD_BITS_DEF + 1 + npbc_pkg::FRAC_PAIRS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       operation,
	output logic                       busy,
	output logic                       done,
	output npbc_pkg::cmd_t             cmd,
	output logic [$clog2(ENTRIES)-1:0] rd_addr
);
	import npbc_pkg::*;

	localparam int AW    = $clog2(ENTRIES);
	localparam int MAXC0 = (ENTRIES > ROOT_STEPS) ? ENTRIES : ROOT_STEPS;
	localparam int MAXC  = (MAXC0 > DRAIN_CYCLES) ? MAXC0 : DRAIN_CYCLES;
	localparam int CW    = $clog2(MAXC);

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] cnt_q;
	logic          accept;

	assign accept = start && (state_q == ST_IDLE);

	// State register and step counter; the counter restarts on every state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CW'(ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == CW'(DRAIN_CYCLES - 1)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (cnt_q == CW'(ROOT_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and status.
	always_comb begin
		cmd            = '0;
		busy           = 1'b1;
		done           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy           = 1'b0;
				cmd.load       = accept && operation == OP_LOAD;
				cmd.scan_clear = accept && operation == OP_QUERY;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_PREP: begin
				cmd.root_init = 1'b1;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign rd_addr = cnt_q[AW-1:0];

endmodule

[design/npbc_dp.sv]
module npbc_dp #(
	parameter int ENTRIES       = npbc_pkg::ENTRIES_DEF,
	parameter int COORD_BITS    = npbc_pkg::COORD_BITS_DEF,
	parameter int CATEGORY_BITS = npbc_pkg::CATEGORY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  npbc_pkg::req_t             request,
	input  npbc_pkg::cmd_t             cmd,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output npbc_pkg::rsp_t             result
);
	import npbc_pkg::*;

	localparam int AW         = $clog2(ENTRIES);
	localparam int D2W        = 2 * COORD_BITS + 1;
	localparam int ROOT_STEPS = COORD_BITS + 1 + FRAC_PAIRS;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int REM_W      = ROOT_STEPS + 1;

	// Table storage; an entry counts in a search only when its valid bit is set.
	logic signed [COORD_BITS-1:0] mem_x [ENTRIES];
	logic signed [COORD_BITS-1:0] mem_y [ENTRIES];
	logic [CATEGORY_BITS-1:0]     mem_cat [ENTRIES];
	logic [ENTRIES-1:0]           valid_q;

	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic [CATEGORY_BITS-1:0]     in_cat;
	logic                         slot_ok;
	logic [AW-1:0]                wr_addr;

	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;
	logic [CATEGORY_BITS-1:0]     qcat_q;

	logic signed [COORD_BITS-1:0] ex_s1;
	logic signed [COORD_BITS-1:0] ey_s1;
	logic [CATEGORY_BITS-1:0]     ecat_s1;
	logic                         ev_s1;
	logic                         v_s1;
	logic [AW-1:0]                idx_s1;

	logic signed [COORD_BITS:0]   diff_x;
	logic signed [COORD_BITS:0]   diff_y;
	logic [COORD_BITS-1:0]        adx;
	logic [COORD_BITS-1:0]        ady;
	logic [COORD_BITS-1:0]        dx_s2;
	logic [COORD_BITS-1:0]        dy_s2;
	logic                         hit_s2;
	logic [AW-1:0]                idx_s2;

	logic [2*COORD_BITS-1:0]      sqx_s3;
	logic [2*COORD_BITS-1:0]      sqy_s3;
	logic                         hit_s3;
	logic [AW-1:0]                idx_s3;

	logic [D2W-1:0]               d2_sum;
	logic                         better;
	logic                         found_q;
	logic [D2W-1:0]               best_d2_q;
	logic [AW-1:0]                best_idx_q;

	logic [RAD_W-1:0]             rad_q;
	logic [REM_W-1:0]             rem_q;
	logic [ROOT_STEPS-1:0]        res_q;
	logic [1:0]                   pair;
	logic [REM_W+1:0]             rem_try;
	logic [REM_W+1:0]             trial;
	logic                         root_ge;
	logic [REM_W+1:0]             rem_next;

	// Request fields cut to the configured widths; coordinates sign extend.
	assign in_x    = COORD_BITS'(request.pos_x);
	assign in_y    = COORD_BITS'(request.pos_y);
	assign in_cat  = CATEGORY_BITS'(request.category);
	assign slot_ok = 32'(request.slot) < ENTRIES;
	assign wr_addr = AW'(request.slot);

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.load && slot_ok) begin
			mem_x[wr_addr]   <= in_x;
			mem_y[wr_addr]   <= in_y;
			mem_cat[wr_addr] <= in_cat;
		end
		if (cmd.issue) begin
			ex_s1   <= mem_x[rd_addr];
			ey_s1   <= mem_y[rd_addr];
			ecat_s1 <= mem_cat[rd_addr];
		end
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.load && slot_ok) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Query point latched when a query is accepted.
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			qx_q   <= in_x;
			qy_q   <= in_y;
			qcat_q <= in_cat;
		end
	end

	// Absolute coordinate differences.
	always_comb begin
		diff_x = (COORD_BITS + 1)'(ex_s1) - (COORD_BITS + 1)'(qx_q);
		diff_y = (COORD_BITS + 1)'(ey_s1) - (COORD_BITS + 1)'(qy_q);
		adx    = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
		ady    = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
	end

	// Pipeline payload: differences, then squares.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		dx_s2  <= adx;
		dy_s2  <= ady;
		idx_s2 <= idx_s1;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		idx_s3 <= idx_s2;
	end

	// Pipeline occupancy and match flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ev_s1  <= 1'b0;
			hit_s2 <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			ev_s1  <= valid_q[rd_addr];
			hit_s2 <= v_s1 && ev_s1 && (ecat_s1 == qcat_q);
			hit_s3 <= hit_s2;
		end
	end

	// Running minimum; only a strictly smaller distance replaces the best,
	// so a tie keeps the lower slot.
	assign d2_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign better = hit_s3 && (!found_q || d2_sum < best_d2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_d2_q  <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan_clear) begin
			found_q    <= 1'b0;
			best_d2_q  <= '0;
			best_idx_q <= '0;
		end else if (better) begin
			found_q    <= 1'b1;
			best_d2_q  <= d2_sum;
			best_idx_q <= idx_s3;
		end
	end

	// One digit of the bitwise square root per step.
	always_comb begin
		pair     = rad_q[RAD_W-1 -: 2];
		rem_try  = {rem_q, pair};
		trial    = {1'b0, res_q, 2'b01};
		root_ge  = rem_try >= trial;
		rem_next = root_ge ? rem_try - trial : rem_try;
	end

	// Root registers; the radicand gets the fraction pairs appended below.
	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rad_q <= {1'b0, best_d2_q, {(2 * FRAC_PAIRS){1'b0}}};
			rem_q <= '0;
			res_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q <= rem_next[REM_W-1:0];
			res_q <= {res_q[ROOT_STEPS-2:0], root_ge};
		end
	end

	// Result fields, all zero when nothing matched.
	always_comb begin
		result                  = '0;
		result.found            = found_q;
		if (found_q) begin
			result.nearest_slot     = SLOT_W'(best_idx_q);
			result.distance_squared = D2_W'(best_d2_q);
			result.distance_q8      = Q8_W'(res_q);
		end
	end

endmodule

[design/npbc_chk.sv]
module npbc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input npbc_pkg::req_t request,
	input logic           done,
	input npbc_pkg::rsp_t result
);
	import npbc_pkg::*;

	// A result only comes out while a query is in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// The block is free again right after the result.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block not idle after result");

	// A load never makes the block busy.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_LOAD) |=> !busy)
		else $error("load made the block busy");

	// An accepted query makes the block busy, with no result yet.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_QUERY) |=> busy && !done)
		else $error("query did not start a search");

	// A miss reports zeros.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.nearest_slot == '0 &&
			result.distance_squared == '0 && result.distance_q8 == '0))
		else $error("miss with nonzero result fields");

endmodule

bind nearest_point_by_category npbc_chk u_npbc_chk (.*);

[tb/nearest_point_checker.sv]
`timescale 1ns / 100ps

// Watches the request and result channels of the nearest-point block. It keeps
// its own copy of the point table, predicts the answer to every accepted query
// and compares each result strobe with the oldest outstanding answer.
module nearest_point_checker
	import npbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic done,
	input  rsp_t result,
	output int   mismatches,
	output int   pending,
	output int   loads_seen,
	output int   answered,
	output int   hits
);

	localparam int SLOTS = 1 << SLOT_W;

	// Shadow copy of the point table.
	logic signed [POS_W-1:0] point_x [SLOTS];
	logic signed [POS_W-1:0] point_y [SLOTS];
	logic [CAT_W-1:0]        point_cat [SLOTS];
	bit                      point_valid [SLOTS];

	// Answers still owed by the block, oldest first.
	rsp_t awaited_answers [$];

	// Floor of sqrt(v) * 256, taken as the integer root of v shifted up by 16 bits.
	function automatic logic [Q8_W-1:0] root_q8(input longint unsigned v);
		longint unsigned radicand, rem, root, trial;
		int i;
		radicand = v << 16;
		rem = 0;
		root = 0;
		for (i = 31; i >= 0; i--) begin
			rem = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[Q8_W-1:0];
	endfunction

	// Scans the valid entries of the wanted category; only a strictly smaller
	// squared distance replaces the best, so the lower slot wins a tie.
	function automatic rsp_t nearest_of(input req_t q);
		rsp_t ans;
		bit seen;
		longint dx, dy;
		longint unsigned d2, best;
		int k;
		ans = '0;
		seen = 0;
		best = 0;
		for (k = 0; k < SLOTS; k++) begin
			if (point_valid[k] && point_cat[k] == q.category) begin
				dx = longint'(point_x[k]) - longint'($signed(q.pos_x));
				dy = longint'(point_y[k]) - longint'($signed(q.pos_y));
				d2 = longint'(dx * dx + dy * dy);
				if (!seen || d2 < best) begin
					seen = 1;
					best = d2;
					ans.nearest_slot = k[SLOT_W-1:0];
				end
			end
		end
		if (seen) begin
			ans.found = 1'b1;
			ans.distance_squared = best[D2_W-1:0];
			ans.distance_q8 = root_q8(best);
		end
		return ans;
	endfunction

	// Counts a failure and reports the first few of them in full.
	task automatic note_failure(input string why, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected found=%0b slot=%0d d2=%0d q8=%0d, got found=%0b slot=%0d d2=%0d q8=%0d",
				$realtime, why, want.found, want.nearest_slot, want.distance_squared,
				want.distance_q8, got.found, got.nearest_slot, got.distance_squared,
				got.distance_q8);
		end
	endtask

	// Result checking and table tracking, both on the rising edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				point_valid[k] = 0;
			end
			awaited_answers.delete();
			mismatches = 0;
			pending = 0;
			loads_seen = 0;
			answered = 0;
			hits = 0;
		end else begin
			// Compare a strobed result with the oldest outstanding answer.
			if (done) begin
				if (awaited_answers.size() == 0) begin
					note_failure("result with no query outstanding", '0, result);
				end else begin
					want = awaited_answers.pop_front();
					answered++;
					if (want.found) begin
						hits++;
					end
					if (result.found !== want.found
						|| result.nearest_slot !== want.nearest_slot
						|| result.distance_squared !== want.distance_squared
						|| result.distance_q8 !== want.distance_q8) begin
						note_failure("wrong query result", want, result);
					end
				end
			end

			// An accepted request either loads a slot or owes one answer.
			if (start && !busy) begin
				if (request.operation == OP_LOAD) begin
					point_x[request.slot] = request.pos_x;
					point_y[request.slot] = request.pos_y;
					point_cat[request.slot] = request.category;
					point_valid[request.slot] = 1;
					loads_seen++;
				end else begin
					awaited_answers.push_back(nearest_of(request));
				end
			end
			pending = awaited_answers.size();
		end
	end

endmodule

[tb/tb_nearest_point_by_category.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the nearest-point block. The checker beside the
// block does all prediction and comparison.
module tb_nearest_point_by_category;
	import npbc_pkg::*;

	localparam int RANDOM_ITEMS = 1780;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE       = 64;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	rsp_t result;

	int mismatches, pending, loads_seen, answered, hits;
	int cycles;

	// A few categories hold most traffic so that queries mostly find points.
	logic [CAT_W-1:0] cat_pool [4];
	int cluster_x, cluster_y;

	nearest_point_by_category dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	nearest_point_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending),
		.loads_seen (loads_seen),
		.answered   (answered),
		.hits       (hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic req_t make_req(input logic op, input logic [SLOT_W-1:0] slot,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [CAT_W-1:0] cat);
		req_t r;
		r.operation = op;
		r.slot = slot;
		r.pos_x = x;
		r.pos_y = y;
		r.category = cat;
		return r;
	endfunction

	// Coordinates: full range, tight clusters that provoke ties, or extremes.
	function automatic logic [POS_W-1:0] pick_coord(input int center);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = int'($urandom);
			4, 5, 6, 7: v = center + $urandom_range(0, 16) - 8;
			default: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
		endcase
		return v[POS_W-1:0];
	endfunction

	function automatic logic [CAT_W-1:0] pick_category();
		if ($urandom_range(0, 99) < 85) begin
			return cat_pool[$urandom_range(0, 3)];
		end
		return CAT_W'($urandom);
	endfunction

	function automatic req_t random_item();
		logic op;
		op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_QUERY;
		return make_req(op, SLOT_W'($urandom), pick_coord(cluster_x), pick_coord(cluster_y),
			pick_category());
	endfunction

	// New categories and cluster centers for the next stretch of traffic.
	task automatic reshuffle();
		for (int k = 0; k < 4; k++) begin
			cat_pool[k] = CAT_W'($urandom);
		end
		cluster_x = $signed(16'($urandom));
		cluster_y = $signed(16'($urandom));
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Presents one request and holds it until the block takes it.
	task automatic send_item(input req_t r, input bit may_gap);
		if (may_gap && $urandom_range(0, 3) == 0) begin
			idle_cycles($urandom_range(1, 3));
		end
		@(negedge clk);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending until every outstanding query has been answered.
	task automatic drain_wait();
		idle_cycles(1);
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		bit quiet;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		reshuffle();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, extreme corners, ties, overwrites.
		send_item(make_req(OP_QUERY, 4'h0, 16'h0000, 16'h0000, 8'h00), 1);
		send_item(make_req(OP_LOAD, 4'h0, 16'h8000, 16'h8000, 8'h00), 1);
		send_item(make_req(OP_LOAD, 4'hF, 16'h7FFF, 16'h7FFF, 8'hFF), 1);
		send_item(make_req(OP_QUERY, 4'h0, 16'h7FFF, 16'h7FFF, 8'h00), 1);
		send_item(make_req(OP_QUERY, 4'hF, 16'h8000, 16'h8000, 8'hFF), 1);
		send_item(make_req(OP_QUERY, 4'h7, 16'h7FFF, 16'h7FFF, 8'hFF), 1);
		send_item(make_req(OP_QUERY, 4'hF, 16'h1234, 16'hFEDC, 8'h5A), 1);
		send_item(make_req(OP_LOAD, 4'h3, 16'd10, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_LOAD, 4'h5, -16'sd10, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_QUERY, 4'h9, 16'd0, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_LOAD, 4'h1, 16'd0, 16'd10, 8'h5A), 1);
		send_item(make_req(OP_QUERY, 4'h0, 16'd0, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_LOAD, 4'h1, 16'd100, 16'd100, 8'h5A), 1);
		send_item(make_req(OP_QUERY, 4'hA, 16'd0, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_LOAD, 4'h3, 16'd10, 16'd0, 8'hA5), 1);
		send_item(make_req(OP_QUERY, 4'h3, 16'd0, 16'd0, 8'h5A), 1);
		send_item(make_req(OP_QUERY, 4'h5, 16'd1, 16'd2, 8'hA5), 1);
		send_item(make_req(OP_LOAD, 4'h7, 16'hFFFF, 16'hFFFF, 8'h5A), 1);
		send_item(make_req(OP_QUERY, 4'hC, 16'd0, 16'd0, 8'h5A), 1);
		drain_wait();

		// Random part, with stretches of no idling and a full drain now and then.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= RANDOM_ITEMS - RANDOM_ITEMS / 8) || ((n / 150) % 3 == 2);
			if (n > 0 && n % 400 == 0) begin
				drain_wait();
				reshuffle();
			end
			send_item(random_item(), !quiet);
		end

		// Let the last answers arrive, then watch for stray strobes.
		drain_wait();
		repeat (SETTLE) @(negedge clk);

		$display("Loaded %0d points and checked %0d queries: %0d found a point, %0d none.",
			loads_seen, answered, hits, answered - hits);
		$display("Covered empty categories, corner-to-corner distances, ties and overwrites.");
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
